### design/cst_pkg.sv
// shared types and codes for the coordinate set table
package cst_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    localparam int IN_DATA_BITS  = 16;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_DATA_BITS = 16;
    localparam int FIELD_BITS    = 8;
    localparam int COUNT_BITS    = 5;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_CLEAR  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic     cmp_en;
        t_cell_op op;
    } t_cell_ctrl;

endpackage

### design/coordinate_set_table.sv
// coordinate set table top level: request control, cell chain and result register
//
//  channel  | direction | tdata                      | tuser
//  s_axis   | in        | coord_x, coord_y           | mode
//  m_axis   | out       | hit, status, count, empty  | -
//
// a request is handled in order: every cell registers its compare when the request is accepted,
// then in S_UPD the chain updates and the result is registered
// the compare-then-shift step through the cell chain sets this order
// reset clears every valid bit and the count
// a stalled result holds the next request off until it is taken
module coordinate_set_table
    import cst_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int COORD_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,  // coord_x[7:0], coord_y[15:8]
    input  logic [IN_USER_BITS-1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata   // hit[0], status[2:1], entry_count[7:3],
                                                      // is_empty[8], zero[15:9]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [1:0]              r_mode;
    logic [COORD_BITS-1:0]   r_x;
    logic [COORD_BITS-1:0]   r_y;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;

    logic                    w_accept;
    logic [15:0]             w_x_wide;
    logic [15:0]             w_y_wide;
    logic [COORD_BITS-1:0]   w_cx;
    logic [COORD_BITS-1:0]   w_cy;
    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_valid;
    logic [CAPACITY-1:0]     w_shift;
    logic [COORD_BITS-1:0]   w_ex [CAPACITY];
    logic [COORD_BITS-1:0]   w_ey [CAPACITY];
    logic [IW-1:0]           w_idx;
    logic                    w_hit;
    logic                    w_full;
    logic [1:0]              w_status;
    t_cell_ctrl              w_ctrl;
    logic [31:0]             w_count_ext;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);

    assign w_x_wide = 16'(i_s_axis_tdata[FIELD_BITS-1:0]);
    assign w_y_wide = 16'(i_s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]);
    assign w_cx     = w_x_wide[COORD_BITS-1:0];
    assign w_cy     = w_y_wide[COORD_BITS-1:0];

    assign w_hit  = |w_match;
    assign w_full = (r_count == CW'(CAPACITY));

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_idx = w_idx | IW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_shift[i] = (IW'(i) >= w_idx);
        end
    end

    always_comb begin
        w_ctrl.cmp_en = w_accept;
        w_ctrl.op     = CELL_HOLD;
        w_status      = STATUS_OK;
        n_count       = r_count;
        if (r_state == S_UPD) begin
            case (r_mode)
                MODE_INSERT: begin
                    if (w_hit) begin
                        w_status = STATUS_DUPLICATE;
                    end else if (w_full) begin
                        w_status = STATUS_FULL;
                    end else begin
                        w_ctrl.op = CELL_INSERT;
                        n_count   = r_count + CW'(1);
                    end
                end
                MODE_REMOVE: begin
                    if (!w_hit) begin
                        w_status = STATUS_NOT_FOUND;
                    end else begin
                        w_ctrl.op = CELL_REMOVE;
                        n_count   = r_count - CW'(1);
                    end
                end
                MODE_CLEAR: begin
                    w_ctrl.op = CELL_CLEAR;
                    n_count   = '0;
                end
                default: begin
                    w_status = STATUS_OK;
                end
            endcase
        end
    end

    assign w_count_ext = 32'(n_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                  w_prev_valid;
            logic                  w_next_valid;
            logic [COORD_BITS-1:0] w_next_x;
            logic [COORD_BITS-1:0] w_next_y;
            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_valid = w_valid[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_next_valid = 1'b0;
                assign w_next_x     = '0;
                assign w_next_y     = '0;
            end else begin : g_inner
                assign w_next_valid = w_valid[g+1];
                assign w_next_x     = w_ex[g+1];
                assign w_next_y     = w_ey[g+1];
            end
            cst_cell #(
                .COORD_BITS(COORD_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_cx        (w_cx),
                .i_cy        (w_cy),
                .i_wx        (r_x),
                .i_wy        (r_y),
                .i_prev_valid(w_prev_valid),
                .i_shift     (w_shift[g]),
                .i_next_valid(w_next_valid),
                .i_next_x    (w_next_x),
                .i_next_y    (w_next_y),
                .o_valid     (w_valid[g]),
                .o_x         (w_ex[g]),
                .o_y         (w_ey[g]),
                .o_match     (w_match[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_UPD) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_s_axis_tuser;
            r_x    <= w_cx;
            r_y    <= w_cy;
        end
        if (r_state == S_UPD) begin
            r_out_data <= {7'd0, (n_count == '0), w_count_ext[COUNT_BITS-1:0], w_status, w_hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("valid cells disagree with entry count");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_match))
        else $error("point stored in more than one cell");

    a_dense_packing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid & ~(w_valid << 1)) && (w_valid == '0 || w_valid[0]))
        else $error("valid cells not packed from slot zero");

    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 r_out_valid)
        else $error("result missing after request");
`endif

endmodule

### design/cst_cell.sv
// one slot of the set: stored point, valid bit and registered match
module cst_cell
    import cst_pkg::*;
#(
    parameter int COORD_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [COORD_BITS-1:0] i_cx,
    input  logic [COORD_BITS-1:0] i_cy,
    input  logic [COORD_BITS-1:0] i_wx,
    input  logic [COORD_BITS-1:0] i_wy,
    input  logic                  i_prev_valid,
    input  logic                  i_shift,
    input  logic                  i_next_valid,
    input  logic [COORD_BITS-1:0] i_next_x,
    input  logic [COORD_BITS-1:0] i_next_y,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic                  o_match
);

    logic                  r_valid;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic                  r_match;
    logic                  n_valid;
    logic [COORD_BITS-1:0] n_x;
    logic [COORD_BITS-1:0] n_y;

    always_comb begin
        n_valid = r_valid;
        n_x     = r_x;
        n_y     = r_y;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_x     = i_wx;
                    n_y     = i_wy;
                end
            end
            CELL_REMOVE: begin
                if (i_shift) begin
                    n_valid = i_next_valid;
                    n_x     = i_next_x;
                    n_y     = i_next_y;
                end
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
                n_x     = '0;
                n_y     = '0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctrl.cmp_en) begin
                r_match <= r_valid && (r_x == i_cx) && (r_y == i_cy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_match = r_match;

endmodule
